// ----- hw/rtl/fingerprint_minutiae_record_checker_unit_defines.svh -----
// Assertion macros shared by the minutiae record checker RTL.
`ifndef FINGERPRINT_MINUTIAE_RECORD_CHECKER_UNIT_DEFINES_SVH
`define FINGERPRINT_MINUTIAE_RECORD_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FMRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fmrc_pkg.sv -----
// Types, limits and field codes for the minutiae record checker.
package fmrc_pkg;

    localparam int unsigned MAX_MINUTIAE     = 128;
    localparam int unsigned MAX_RECORD_BYTES = 1574;
    localparam int unsigned COUNT_W          = $clog2(MAX_RECORD_BYTES + 1);

    localparam int unsigned HEADER_BYTES = 26;
    localparam int unsigned TAG_BYTES    = 8;

    // Header byte positions (low 5 bits of the byte count)
    localparam logic [4:0] HDR_POS_LENGTH = 5'd9;
    localparam logic [4:0] HDR_POS_OWNER  = 5'd11;
    localparam logic [4:0] HDR_POS_TYPE   = 5'd13;
    localparam logic [4:0] HDR_POS_EQUIP  = 5'd15;
    localparam logic [4:0] HDR_POS_WIDTH  = 5'd17;
    localparam logic [4:0] HDR_POS_HEIGHT = 5'd19;
    localparam logic [4:0] HDR_POS_XRES   = 5'd21;
    localparam logic [4:0] HDR_POS_YRES   = 5'd23;
    localparam logic [4:0] HDR_POS_VIEWS  = 5'd24;
    localparam logic [4:0] HDR_POS_RSVD   = 5'd25;

    localparam logic [15:0] RESOLUTION       = 16'd197;
    localparam logic [3:0]  EQUIP_COMPLIANCE = 4'h8;
    localparam logic [7:0]  VIEWS_PER_RECORD = 8'd2;
    localparam logic [7:0]  POSITION_MAX     = 8'd10;
    localparam logic [7:0]  IMPR_LIVE_PLAIN  = 8'd0;
    localparam logic [7:0]  IMPR_NONLIVE     = 8'd2;
    localparam logic [7:0]  ANGLE_MAX        = 8'd179;
    localparam logic [7:0]  MIN_QUALITY_MAX  = 8'd100;
    localparam logic [1:0]  MIN_TYPE_RSVD    = 2'd3;

    // Field counter values
    localparam logic [2:0] FC_VIEW_POS    = 3'd0;
    localparam logic [2:0] FC_VIEW_IMPR   = 3'd1;
    localparam logic [2:0] FC_VIEW_QUAL   = 3'd2;
    localparam logic [2:0] FC_VIEW_COUNT  = 3'd3;
    localparam logic [2:0] FC_MIN_XHI     = 3'd0;
    localparam logic [2:0] FC_MIN_XLO     = 3'd1;
    localparam logic [2:0] FC_MIN_YHI     = 3'd2;
    localparam logic [2:0] FC_MIN_YLO     = 3'd3;
    localparam logic [2:0] FC_MIN_ANGLE   = 3'd4;
    localparam logic [2:0] FC_MIN_QUAL    = 3'd5;
    localparam logic [2:0] FC_EXT_HI      = 3'd0;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_VIEW    = 4'd1,
        PH_MINUTIA = 4'd2,
        PH_EXT     = 4'd3,
        PH_DONE    = 4'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] owner_id;
        logic [15:0] type_id;
        logic [15:0] equip_id;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

    // "FMR\0" then " 20\0"
    function automatic logic [7:0] tag_byte(input logic [2:0] idx);
        logic [7:0] t;
        case (idx)
            3'd0:    t = 8'h46;
            3'd1:    t = 8'h4D;
            3'd2:    t = 8'h52;
            3'd3:    t = 8'h00;
            3'd4:    t = 8'h20;
            3'd5:    t = 8'h32;
            3'd6:    t = 8'h30;
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    function automatic logic quality_ok(input logic [7:0] q);
        return (q == 8'd20) || (q == 8'd40) || (q == 8'd60) || (q == 8'd80) ||
               (q == 8'd100) || (q == 8'd254) || (q == 8'd255);
    endfunction

endpackage

// ----- hw/rtl/fingerprint_minutiae_record_checker_unit.sv -----
// Minutiae record checker: byte-stream rule checker with one verdict per record.
//
// Takes a fingerprint minutiae record one byte per word, with a last flag on
// the final byte, and checks the header tags, declared length, identifiers,
// image size, resolution, two finger views, every minutia and the two zero
// extension lengths as the bytes stream through. A failure is sticky until
// the end of the record. When the last byte has been processed one result
// word comes out: status (0 valid, 1 invalid) plus the owner, type, capture
// equipment, width and height words from the header (0 for any header field
// that never arrived). Records longer than MAX_RECORD_BYTES are flagged
// invalid and the byte count saturates. No result is produced for bytes
// other than the last; after the result the checker is back at the start of
// a record. Rate: one byte per clock while no last byte waits on the output.
// Each byte is registered in the input register and checked there against
// the record state; when the last byte is processed there, the result word
// is written to the output register. A last byte is held in the input
// register only while a previous result word is still waiting on the output.
`include "fingerprint_minutiae_record_checker_unit_defines.svh"

module fingerprint_minutiae_record_checker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fmrc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output fmrc_pkg::result_t result
);

    localparam int unsigned CW = fmrc_pkg::COUNT_W;

    // input register
    logic              stage_valid_reg;
    fmrc_pkg::item_t   stage_item_reg;

    // record state
    logic [CW-1:0]     count_reg,         count_next;
    logic              overflow_reg,      overflow_next;
    fmrc_pkg::phase_t  phase_reg,         phase_next;
    logic [2:0]        fc_reg,            fc_next;
    logic [7:0]        prev_byte_reg;
    logic [15:0]       declared_len_reg,  declared_len_next;
    logic [15:0]       owner_reg,         owner_next;
    logic [15:0]       type_reg,          type_next;
    logic [15:0]       equip_reg,         equip_next;
    logic [15:0]       width_reg,         width_next;
    logic [15:0]       height_reg,        height_next;
    logic [3:0]        first_pos_reg,     first_pos_next;
    logic              view_idx_reg,      view_idx_next;
    logic [7:0]        min_left_reg,      min_left_next;
    logic              error_reg,         error_next;

    // output register
    logic              result_valid_reg;
    fmrc_pkg::result_t result_reg;

    logic              out_free;
    logic              proc_go;
    logic [7:0]        b;
    logic [15:0]       w;
    logic [CW-1:0]     pos;
    logic [7:0]        min_dec;
    logic              status_now;

    // ---- handshake --------------------------------------------------------
    // Only a last byte needs room in the output register.
    assign out_free   = !result_valid_reg || result_ready;
    assign proc_go    = stage_valid_reg && (!stage_item_reg.last || out_free);
    assign item_ready = !stage_valid_reg || proc_go;

    assign b       = stage_item_reg.data_byte;
    assign w       = {prev_byte_reg, b};
    assign pos     = count_reg;
    assign min_dec = min_left_reg - 8'd1;

    // ---- byte count, saturating at the record limit -----------------------
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (pos >= CW'(fmrc_pkg::MAX_RECORD_BYTES))
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            count_next = pos + CW'(1);
        end
    end

    // ---- phase sequencer: next state --------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        fc_next       = fc_reg;
        min_left_next = min_left_reg;
        view_idx_next = view_idx_reg;
        unique case (phase_reg)
            fmrc_pkg::PH_HEADER:
            begin
                if (pos == CW'(fmrc_pkg::HDR_POS_RSVD))
                begin
                    phase_next = fmrc_pkg::PH_VIEW;
                    fc_next    = 3'd0;
                end
            end
            fmrc_pkg::PH_VIEW:
            begin
                if (fc_reg >= fmrc_pkg::FC_VIEW_COUNT)
                begin
                    min_left_next = b;
                    phase_next    = (b != 8'd0) ? fmrc_pkg::PH_MINUTIA : fmrc_pkg::PH_EXT;
                    fc_next       = 3'd0;
                end
                else
                begin
                    fc_next = fc_reg + 3'd1;
                end
            end
            fmrc_pkg::PH_MINUTIA:
            begin
                if (fc_reg >= fmrc_pkg::FC_MIN_QUAL)
                begin
                    min_left_next = min_dec;
                    if (min_dec == 8'd0)
                    begin
                        phase_next = fmrc_pkg::PH_EXT;
                    end
                    fc_next = 3'd0;
                end
                else
                begin
                    fc_next = fc_reg + 3'd1;
                end
            end
            fmrc_pkg::PH_EXT:
            begin
                if (fc_reg == fmrc_pkg::FC_EXT_HI)
                begin
                    fc_next = 3'd1;
                end
                else
                begin
                    fc_next = 3'd0;
                    if (!view_idx_reg)
                    begin
                        view_idx_next = 1'b1;
                        phase_next    = fmrc_pkg::PH_VIEW;
                    end
                    else
                    begin
                        phase_next = fmrc_pkg::PH_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---- phase sequencer: field checks and captures -----------------------
    always_comb
    begin
        error_next        = error_reg;
        declared_len_next = declared_len_reg;
        owner_next        = owner_reg;
        type_next         = type_reg;
        equip_next        = equip_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        first_pos_next    = first_pos_reg;
        unique case (phase_reg)
            fmrc_pkg::PH_HEADER:
            begin
                if (pos >= CW'(fmrc_pkg::HEADER_BYTES))
                begin
                    error_next = 1'b1;
                end
                else if (pos < CW'(fmrc_pkg::TAG_BYTES))
                begin
                    if (b != fmrc_pkg::tag_byte(pos[2:0]))
                    begin
                        error_next = 1'b1;
                    end
                end
                else
                begin
                    unique case (pos[4:0])
                        fmrc_pkg::HDR_POS_LENGTH: declared_len_next = w;
                        fmrc_pkg::HDR_POS_OWNER:
                        begin
                            owner_next = w;
                            if (w == 16'd0) error_next = 1'b1;
                        end
                        fmrc_pkg::HDR_POS_TYPE:
                        begin
                            type_next = w;
                            if (w == 16'd0) error_next = 1'b1;
                        end
                        fmrc_pkg::HDR_POS_EQUIP:
                        begin
                            equip_next = w;
                            if (w[15:12] != fmrc_pkg::EQUIP_COMPLIANCE || w[11:0] == 12'd0)
                            begin
                                error_next = 1'b1;
                            end
                        end
                        fmrc_pkg::HDR_POS_WIDTH:
                        begin
                            width_next = w;
                            if (w == 16'd0) error_next = 1'b1;
                        end
                        fmrc_pkg::HDR_POS_HEIGHT:
                        begin
                            height_next = w;
                            if (w == 16'd0) error_next = 1'b1;
                        end
                        fmrc_pkg::HDR_POS_XRES, fmrc_pkg::HDR_POS_YRES:
                        begin
                            if (w != fmrc_pkg::RESOLUTION) error_next = 1'b1;
                        end
                        fmrc_pkg::HDR_POS_VIEWS:
                        begin
                            if (b != fmrc_pkg::VIEWS_PER_RECORD) error_next = 1'b1;
                        end
                        fmrc_pkg::HDR_POS_RSVD:
                        begin
                            if (b != 8'd0) error_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fmrc_pkg::PH_VIEW:
            begin
                case (fc_reg)
                    fmrc_pkg::FC_VIEW_POS:
                    begin
                        if (b > fmrc_pkg::POSITION_MAX ||
                            (view_idx_reg && b == {4'd0, first_pos_reg}))
                        begin
                            error_next = 1'b1;
                        end
                        if (!view_idx_reg)
                        begin
                            first_pos_next = b[3:0];
                        end
                    end
                    fmrc_pkg::FC_VIEW_IMPR:
                    begin
                        if (b != fmrc_pkg::IMPR_LIVE_PLAIN && b != fmrc_pkg::IMPR_NONLIVE)
                        begin
                            error_next = 1'b1;
                        end
                    end
                    fmrc_pkg::FC_VIEW_QUAL:
                    begin
                        if (!fmrc_pkg::quality_ok(b)) error_next = 1'b1;
                    end
                    default:
                    begin
                        if (b > 8'(fmrc_pkg::MAX_MINUTIAE)) error_next = 1'b1;
                    end
                endcase
            end
            fmrc_pkg::PH_MINUTIA:
            begin
                case (fc_reg)
                    fmrc_pkg::FC_MIN_XHI:
                    begin
                        if (b[7:6] == fmrc_pkg::MIN_TYPE_RSVD) error_next = 1'b1;
                    end
                    fmrc_pkg::FC_MIN_XLO:
                    begin
                        if ({2'b00, w[13:0]} >= width_reg) error_next = 1'b1;
                    end
                    fmrc_pkg::FC_MIN_YHI:
                    begin
                        if (b[7:6] != 2'b00) error_next = 1'b1;
                    end
                    fmrc_pkg::FC_MIN_YLO:
                    begin
                        if ({2'b00, w[13:0]} >= height_reg) error_next = 1'b1;
                    end
                    fmrc_pkg::FC_MIN_ANGLE:
                    begin
                        if (b > fmrc_pkg::ANGLE_MAX) error_next = 1'b1;
                    end
                    default:
                    begin
                        if (b > fmrc_pkg::MIN_QUALITY_MAX) error_next = 1'b1;
                    end
                endcase
            end
            fmrc_pkg::PH_EXT:
            begin
                if (b != 8'd0) error_next = 1'b1;
            end
            default:
            begin
                // trailing bytes after the second extension length
                error_next = 1'b1;
            end
        endcase
    end

    assign status_now = error_next || overflow_next ||
                        (phase_next != fmrc_pkg::PH_DONE) ||
                        (declared_len_next != 16'(count_next));

    // ---- input register ---------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
    end

    // ---- record state: cleared at reset and after every last byte ---------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            phase_reg        <= fmrc_pkg::PH_HEADER;
            fc_reg           <= 3'd0;
            prev_byte_reg    <= 8'd0;
            declared_len_reg <= 16'd0;
            owner_reg        <= 16'd0;
            type_reg         <= 16'd0;
            equip_reg        <= 16'd0;
            width_reg        <= 16'd0;
            height_reg       <= 16'd0;
            first_pos_reg    <= 4'd0;
            view_idx_reg     <= 1'b0;
            min_left_reg     <= 8'd0;
            error_reg        <= 1'b0;
        end
        else if (proc_go)
        begin
            if (stage_item_reg.last)
            begin
                count_reg        <= '0;
                overflow_reg     <= 1'b0;
                phase_reg        <= fmrc_pkg::PH_HEADER;
                fc_reg           <= 3'd0;
                prev_byte_reg    <= 8'd0;
                declared_len_reg <= 16'd0;
                owner_reg        <= 16'd0;
                type_reg         <= 16'd0;
                equip_reg        <= 16'd0;
                width_reg        <= 16'd0;
                height_reg       <= 16'd0;
                first_pos_reg    <= 4'd0;
                view_idx_reg     <= 1'b0;
                min_left_reg     <= 8'd0;
                error_reg        <= 1'b0;
            end
            else
            begin
                count_reg        <= count_next;
                overflow_reg     <= overflow_next;
                phase_reg        <= phase_next;
                fc_reg           <= fc_next;
                prev_byte_reg    <= b;
                declared_len_reg <= declared_len_next;
                owner_reg        <= owner_next;
                type_reg         <= type_next;
                equip_reg        <= equip_next;
                width_reg        <= width_next;
                height_reg       <= height_next;
                first_pos_reg    <= first_pos_next;
                view_idx_reg     <= view_idx_next;
                min_left_reg     <= min_left_next;
                error_reg        <= error_next;
            end
        end
    end

    // ---- output register --------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (proc_go && stage_item_reg.last)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && stage_item_reg.last)
        begin
            result_reg.status       <= status_now;
            result_reg.owner_id     <= owner_next;
            result_reg.type_id      <= type_next;
            result_reg.equip_id     <= equip_next;
            result_reg.image_width  <= width_next;
            result_reg.image_height <= height_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---- assertions -------------------------------------------------------
    `FMRC_ASSERT_NOW(a_count_bounded, 1'b1,
        count_reg <= CW'(fmrc_pkg::MAX_RECORD_BYTES), "byte count beyond record limit")
    `FMRC_ASSERT_NOW(a_overflow_saturated, overflow_reg,
        count_reg == CW'(fmrc_pkg::MAX_RECORD_BYTES), "overflow without saturated count")
    `FMRC_ASSERT_NOW(a_minutia_pending, phase_reg == fmrc_pkg::PH_MINUTIA,
        min_left_reg != 8'd0, "minutia phase with no minutiae left")
    `FMRC_ASSERT_NEXT(a_last_gives_result, proc_go && stage_item_reg.last,
        result_valid_reg, "last byte processed without a result")
    `FMRC_ASSERT_NEXT(a_last_restarts, proc_go && stage_item_reg.last,
        phase_reg == fmrc_pkg::PH_HEADER && count_reg == '0 && !error_reg,
        "record state not cleared after last byte")

endmodule
